// ===== rtl/gds_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date stepper.
`timescale 1ns / 1ps

package gds_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_FWD  = 2'd1,
		REQ_BACK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIX,
		ST_STEP,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic accept;   // latch the request fields
		logic fix;      // clamp the loaded day to the month length
		logic step;     // take one day step and count down
		logic publish;  // copy the date into the result register
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
	} status_t;

	localparam logic [15:0] YEAR_RESET = 16'd1970;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;
	localparam logic [4:0]  DAY_FIRST  = 5'd1;
	localparam logic [4:0]  DAY_MAX    = 5'd31;

	// y divisible by 25 <=> (y * 25^-1 mod 2^16) <= floor(65535 / 25)
	localparam logic [15:0] INV25      = 16'd23593;
	localparam logic [15:0] DIV25_MAX  = 16'd2621;

	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/gds_if.sv =====
// Valid/ready channel interfaces for requests and resulting dates.
`timescale 1ns / 1ps

interface gds_req_if import gds_pkg::*; ();
	logic        valid;
	logic        ready;
	req_t        req_type;
	logic [15:0] load_year;
	logic [3:0]  load_month;
	logic [4:0]  load_day;
	logic [15:0] day_count;

	modport source (output valid, req_type, load_year, load_month, load_day, day_count,
		input ready);
	modport sink (input valid, req_type, load_year, load_month, load_day, day_count,
		output ready);
endinterface

interface gds_res_if ();
	logic        valid;
	logic        ready;
	logic [15:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;

	modport source (output valid, cur_year, cur_month, cur_day, input ready);
	modport sink (input valid, cur_year, cur_month, cur_day, output ready);
endinterface

// ===== rtl/gds_ctrl.sv =====
// Request sequencer for the date stepper: accept, fix, step and result handoff.
`timescale 1ns / 1ps

module gds_ctrl import gds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  req_t    req_type,
	output logic    req_ready,
	output logic    res_valid,
	input  logic    res_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_type)
						REQ_LOAD:           state_d = ST_FIX;
						REQ_FWD, REQ_BACK:  state_d = ST_STEP;
						default:            state_d = ST_WRITE;
					endcase
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_WRITE;
			end
			ST_STEP: begin
				if (status.cnt_zero) begin
					state_d = ST_WRITE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_WRITE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/gds_datapath.sv =====
// Date registers, day-step logic, step counter and result register.
`timescale 1ns / 1ps

module gds_datapath import gds_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  req_t        req_type,
	input  logic [15:0] load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	input  logic [15:0] day_count,
	output logic [15:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day
);

	logic [15:0]            year_q;
	logic [3:0]             month_q;
	logic [4:0]             day_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   back_q;
	logic [15:0]            res_year_q;
	logic [3:0]             res_month_q;
	logic [4:0]             res_day_q;

	logic [15:0] prod;
	logic        div25;
	logic        leap;
	logic [4:0]  last_day;
	logic [3:0]  month_clamp;
	logic [3:0]  month_prev;

	assign prod        = year_q * INV25;
	assign div25       = prod <= DIV25_MAX;
	assign leap        = (year_q[1:0] == 2'd0) && (!div25 || (year_q[3:0] == 4'd0));
	assign last_day    = days_in(month_q, leap);
	assign month_prev  = month_q - 4'd1;
	assign month_clamp = (load_month == 4'd0) ? MONTH_JAN :
		(load_month > MONTH_DEC) ? MONTH_DEC : load_month;

	assign status.cnt_zero = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= YEAR_RESET;
			month_q <= MONTH_JAN;
			day_q   <= DAY_FIRST;
			cnt_q   <= '0;
			back_q  <= 1'b0;
		end else if (cmd.accept) begin
			back_q <= (req_type == REQ_BACK);
			cnt_q  <= COUNT_WIDTH'(day_count);
			if (req_type == REQ_LOAD) begin
				year_q  <= load_year;
				month_q <= month_clamp;
				day_q   <= load_day;
			end
		end else if (cmd.fix) begin
			if (day_q == 5'd0) begin
				day_q <= DAY_FIRST;
			end else if (day_q > last_day) begin
				day_q <= last_day;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
			if (!back_q) begin
				if (day_q < last_day) begin
					day_q <= day_q + 5'd1;
				end else if (month_q >= MONTH_DEC) begin
					year_q  <= year_q + 16'd1;
					month_q <= MONTH_JAN;
					day_q   <= DAY_FIRST;
				end else begin
					month_q <= month_q + 4'd1;
					day_q   <= DAY_FIRST;
				end
			end else begin
				if (day_q > DAY_FIRST) begin
					day_q <= day_q - 5'd1;
				end else if (month_q <= MONTH_JAN) begin
					year_q  <= year_q - 16'd1;
					month_q <= MONTH_DEC;
					day_q   <= DAY_MAX;
				end else begin
					month_q <= month_prev;
					day_q   <= days_in(month_prev, leap);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res_year_q  <= year_q;
			res_month_q <= month_q;
			res_day_q   <= day_q;
		end
	end

	assign cur_year  = res_year_q;
	assign cur_month = res_month_q;
	assign cur_day   = res_day_q;

endmodule

// ===== rtl/gregorian_date_stepper_core.sv =====
// Top level of the Gregorian date stepper.
`timescale 1ns / 1ps

// Holds a calendar date, 1970-01-01 after reset, and answers every request with
// exactly one result: the date held afterwards. A load request clamps the month
// to 1..12 and the day to the month length and goes through the fix and write
// states; a step request stays in the step state until day_count days are
// taken, the calendar datapath moving exactly one day per cycle, then goes to
// the write state; an unused request code goes straight there. One request is
// in work at a time; the next one is taken once the previous date sits in the
// result register, even if that result has not yet been transferred. Years
// wrap modulo 65536; only the low COUNT_WIDTH bits of day_count are used.
module gregorian_date_stepper_core import gds_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	gds_req_if.sink      req,
	gds_res_if.source    res
);

	cmd_t    cmd;
	status_t status;

	gds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gds_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.req_type   (req.req_type),
		.load_year  (req.load_year),
		.load_month (req.load_month),
		.load_day   (req.load_day),
		.day_count  (req.day_count),
		.cur_year   (res.cur_year),
		.cur_month  (res.cur_month),
		.cur_day    (res.cur_day)
	);

endmodule

// ===== rtl/gds_checker.sv =====
// Port-level assertions for the date stepper, bound to the top level.
`timescale 1ns / 1ps

module gds_checker import gds_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input req_t        req_type,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] cur_year,
	input logic [3:0]  cur_month,
	input logic [4:0]  cur_day
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(cur_year) && $stable(cur_month)
			&& $stable(cur_day))
		else $error("result changed while stalled");

	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cur_month >= MONTH_JAN && cur_month <= MONTH_DEC
			&& cur_day >= DAY_FIRST && cur_day <= DAY_MAX)
		else $error("result is not a valid date");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");

	a_none_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_NONE && !res_valid |=> ##1 res_valid)
		else $error("unused request code gave no timely result");

endmodule

bind gregorian_date_stepper_core gds_checker u_gds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.cur_year  (res.cur_year),
	.cur_month (res.cur_month),
	.cur_day   (res.cur_day)
);
